[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

[hdl/ffsa_pkg.sv]
// Shared constants, codes and types of the first-fit segment allocator.
`default_nettype none
package ffsa_pkg;
	localparam int POOL_BYTES   = 1024;
	localparam int MAX_SEGMENTS = 32;
	localparam int START_W = $clog2(POOL_BYTES);
	localparam int SIZE_W  = $clog2(POOL_BYTES) + 1;
	localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int REQ_W   = 11;
	localparam int ADDR_W  = 10;
	localparam int CMP_W   = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EVAL   = 4'b0010,
		S_COMMIT = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic commit;
	} cmd_t;
endpackage
`default_nettype wire

[hdl/ffsa_ctrl.sv]
// Controller state machine that sequences one transaction through the datapath.
`default_nettype none
module ffsa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output ffsa_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done
);
	ffsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffsa_pkg::S_IDLE:   if (start) state_d = ffsa_pkg::S_EVAL;
			ffsa_pkg::S_EVAL:   state_d = ffsa_pkg::S_COMMIT;
			ffsa_pkg::S_COMMIT: state_d = ffsa_pkg::S_REPORT;
			ffsa_pkg::S_REPORT: state_d = ffsa_pkg::S_IDLE;
			default:            state_d = ffsa_pkg::S_IDLE;
		endcase
	end

	assign busy        = (state_q != ffsa_pkg::S_IDLE);
	assign done        = (state_q == ffsa_pkg::S_REPORT);
	assign cmd.capture = (state_q == ffsa_pkg::S_IDLE) && start;
	assign cmd.eval    = (state_q == ffsa_pkg::S_EVAL);
	assign cmd.commit  = (state_q == ffsa_pkg::S_COMMIT);
endmodule
`default_nettype wire

[hdl/ffsa_datapath.sv]
// Segment table cells, first-match search and split-and-shift update.
`default_nettype none
module ffsa_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ffsa_pkg::cmd_t               cmd,
	input  wire logic                         action,
	input  wire logic [ffsa_pkg::REQ_W-1:0]   request_size,
	input  wire logic [ffsa_pkg::ADDR_W-1:0]  address,
	output logic [ffsa_pkg::ADDR_W-1:0]       granted_address,
	output logic [1:0]                        status
);
	localparam int N = ffsa_pkg::MAX_SEGMENTS;

	logic [ffsa_pkg::START_W-1:0] start_q [N];
	logic [ffsa_pkg::SIZE_W-1:0]  size_q  [N];
	logic [N-1:0]                 used_q;
	logic [ffsa_pkg::COUNT_W-1:0] count_q;

	logic                         action_q;
	logic [ffsa_pkg::REQ_W-1:0]   req_q;
	logic [ffsa_pkg::ADDR_W-1:0]  addr_q;
	logic [N-1:0]                 first_q;
	logic                         found_q;
	logic                         full_q;

	logic [N-1:0]                 match;
	logic [N-1:0]                 after;
	logic [ffsa_pkg::START_W-1:0] hit_start;
	logic                         do_split;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (action_q == ffsa_pkg::ACT_ALLOC) begin
				match[i] = (i < int'(count_q)) && !used_q[i] &&
					(ffsa_pkg::CMP_W'(size_q[i]) > ffsa_pkg::CMP_W'(req_q));
			end else begin
				match[i] = (i < int'(count_q)) &&
					(start_q[i] == ffsa_pkg::START_W'(addr_q));
			end
		end
	end

	assign after = ~(first_q | (first_q - N'(1)));
	assign do_split = (action_q == ffsa_pkg::ACT_ALLOC) && found_q && !full_q;

	always_comb begin
		hit_start = '0;
		for (int i = 0; i < N; i++) begin
			hit_start = hit_start | (start_q[i] & {ffsa_pkg::START_W{first_q[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			req_q    <= request_size;
			addr_q   <= address;
		end
		if (cmd.eval) begin
			first_q <= match & (~match + N'(1));
			found_q <= |match;
			full_q  <= (count_q >= ffsa_pkg::COUNT_W'(N));
		end
		if (cmd.commit) begin
			if (action_q == ffsa_pkg::ACT_FREE) begin
				granted_address <= '0;
				status <= found_q ? ffsa_pkg::ST_OK : ffsa_pkg::ST_NOT_FOUND;
			end else if (!found_q) begin
				granted_address <= '0;
				status <= ffsa_pkg::ST_NO_FIT;
			end else if (full_q) begin
				granted_address <= '0;
				status <= ffsa_pkg::ST_FULL;
			end else begin
				granted_address <= ffsa_pkg::ADDR_W'(hit_start);
				status <= ffsa_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				start_q[i] <= '0;
				size_q[i]  <= '0;
			end
			size_q[0] <= ffsa_pkg::SIZE_W'(ffsa_pkg::POOL_BYTES);
			used_q    <= '0;
			count_q   <= ffsa_pkg::COUNT_W'(1);
		end else if (cmd.commit) begin
			if (action_q == ffsa_pkg::ACT_FREE) begin
				if (found_q) used_q <= used_q & ~first_q;
			end else if (do_split) begin
				count_q <= count_q + ffsa_pkg::COUNT_W'(1);
				for (int i = 0; i < N; i++) begin
					if (first_q[i]) begin
						size_q[i] <= ffsa_pkg::SIZE_W'(req_q);
						used_q[i] <= 1'b1;
					end
				end
				for (int i = 1; i < N; i++) begin
					if (after[i]) begin
						if (first_q[i-1]) begin
							start_q[i] <= start_q[i-1] + ffsa_pkg::START_W'(req_q);
							size_q[i]  <= size_q[i-1] - ffsa_pkg::SIZE_W'(req_q);
							used_q[i]  <= 1'b0;
						end else begin
							start_q[i] <= start_q[i-1];
							size_q[i]  <= size_q[i-1];
							used_q[i]  <= used_q[i-1];
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

[hdl/first_fit_segment_allocator.sv]
// Top level of the first-fit segment allocator.
//
// Usage: present action, request_size and address with start high; the
// transaction is accepted at a clock edge where start is high and busy is low.
// An allocate action splits the first free segment strictly larger than the
// request and returns its start on granted_address; a free action clears the
// allocated flag of the first segment starting at address, without merging.
// Every transaction gives exactly one result: done is high for one cycle
// while granted_address and status hold it. The receiver cannot stall.
// Sequence: the controller steps through capture at acceptance, parallel
// search over the segment cells, split-and-shift of the cell chain, and
// report. The result is registered in the split-and-shift step and held on
// the ports through report, where it is taken and busy drops, so a new
// transaction is accepted only after the previous one has reported.
// Status: 0 ok, 1 no fitting segment, 2 table full, 3 offset not found.
// Reset: the table holds one free segment covering the whole pool; the block
// is idle and ready to accept a transaction as soon as reset is released.
`default_nettype none
module first_fit_segment_allocator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         action,
	input  wire logic [ffsa_pkg::REQ_W-1:0]   request_size,
	input  wire logic [ffsa_pkg::ADDR_W-1:0]  address,
	output logic                              done,
	output logic [ffsa_pkg::ADDR_W-1:0]       granted_address,
	output logic [1:0]                        status
);
	ffsa_pkg::cmd_t cmd;

	ffsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ffsa_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (action),
		.request_size    (request_size),
		.address         (address),
		.granted_address (granted_address),
		.status          (status)
	);
endmodule
`default_nettype wire

[hdl/ffsa_checker.sv]
// Port-level checker of the allocator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module ffsa_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [ffsa_pkg::ADDR_W-1:0] granted_address,
	input wire logic [1:0]                  status
);
	logic accept;
	assign accept = start && !busy;

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`ASSERT_IMPL(a_result_timing, clk, arst_n, accept, ##3 done)
	`ASSERT_NEXT(a_single_strobe, clk, arst_n, done, !done && !busy)
	`ASSERT_IMPL(a_fail_no_grant, clk, arst_n, done && (status != ffsa_pkg::ST_OK),
		granted_address == '0)
endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.granted_address (granted_address),
	.status          (status)
);
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench of the first-fit segment allocator with its own table predictor.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ffsa_pkg::ADDR_W-1:0] granted;
		logic [1:0]                  code;
	} grant_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          action;
	logic [ffsa_pkg::REQ_W-1:0]    request_size;
	logic [ffsa_pkg::ADDR_W-1:0]   address;
	logic                          done;
	logic [ffsa_pkg::ADDR_W-1:0]   granted_address;
	logic [1:0]                    status;

	int unsigned seg_base [ffsa_pkg::MAX_SEGMENTS];
	int unsigned seg_len  [ffsa_pkg::MAX_SEGMENTS];
	bit          seg_taken[ffsa_pkg::MAX_SEGMENTS];
	int unsigned seg_total;

	grant_t pending_grants[$];
	int     mismatches;
	int     cycles;

	first_fit_segment_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.request_size(request_size), .address(address), .done(done),
		.granted_address(granted_address), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic grant_t predict_allocation(logic act, int unsigned req,
			int unsigned addr);
		grant_t g;
		int     hit;
		g.granted = '0;
		g.code = ffsa_pkg::ST_OK;
		hit = -1;
		if (act == ffsa_pkg::ACT_ALLOC) begin
			for (int i = 0; i < seg_total; i++) begin
				if (!seg_taken[i] && seg_len[i] > req) begin
					hit = i;
					break;
				end
			end
			if (hit < 0) begin
				g.code = ffsa_pkg::ST_NO_FIT;
			end else if (seg_total >= ffsa_pkg::MAX_SEGMENTS) begin
				g.code = ffsa_pkg::ST_FULL;
			end else begin
				for (int i = seg_total; i > hit + 1; i--) begin
					seg_base[i] = seg_base[i-1];
					seg_len[i] = seg_len[i-1];
					seg_taken[i] = seg_taken[i-1];
				end
				seg_base[hit+1] = seg_base[hit] + req;
				seg_len[hit+1] = seg_len[hit] - req;
				seg_taken[hit+1] = 1'b0;
				seg_len[hit] = req;
				seg_taken[hit] = 1'b1;
				seg_total++;
				g.granted = seg_base[hit][ffsa_pkg::ADDR_W-1:0];
			end
		end else begin
			g.code = ffsa_pkg::ST_NOT_FOUND;
			for (int i = 0; i < seg_total; i++) begin
				if (seg_base[i] == addr) begin
					seg_taken[i] = 1'b0;
					g.code = ffsa_pkg::ST_OK;
					break;
				end
			end
		end
		return g;
	endfunction

	function automatic int unsigned random_gap();
		if ($urandom_range(0, 9) < 4)
			return 0;
		else if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	task automatic send_request(logic act, int unsigned req, int unsigned addr, int unsigned gap);
		start <= 1'b1;
		action <= act;
		request_size <= req[ffsa_pkg::REQ_W-1:0];
		address <= addr[ffsa_pkg::ADDR_W-1:0];
		do begin
			@(negedge clk);
		end while (busy);
		@(posedge clk);
		pending_grants.push_back(predict_allocation(act, req[ffsa_pkg::REQ_W-1:0],
			addr[ffsa_pkg::ADDR_W-1:0]));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_directed();
		send_request(ffsa_pkg::ACT_ALLOC, 1024, 0, random_gap());
		send_request(ffsa_pkg::ACT_ALLOC, 2047, 1023, random_gap());
		send_request(ffsa_pkg::ACT_ALLOC, 1023, 0, 0);
		send_request(ffsa_pkg::ACT_FREE, 0, 0, 0);
		send_request(ffsa_pkg::ACT_FREE, 2047, 1023, random_gap());
		send_request(ffsa_pkg::ACT_FREE, 0, 5, random_gap());
		send_request(ffsa_pkg::ACT_ALLOC, 0, 0, 0);
		send_request(ffsa_pkg::ACT_FREE, 0, 0, 1);
		send_request(ffsa_pkg::ACT_ALLOC, 1, 0, 0);
		send_request(ffsa_pkg::ACT_ALLOC, 512, 0, 2);
		send_request(ffsa_pkg::ACT_ALLOC, 1024, 0, 0);
		send_request(ffsa_pkg::ACT_FREE, 0, 1, 0);
		send_request(ffsa_pkg::ACT_ALLOC, 256, 0, random_gap());
	endtask

	task automatic test_drain();
		start <= 1'b0;
		wait (pending_grants.size() == 0);
		@(posedge clk);
	endtask

	task automatic test_random(int unsigned count);
		int unsigned pick;
		int unsigned req;
		int unsigned addr;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			req = $urandom_range(1, 40);
			addr = $urandom_range(0, 1023);
			if (seg_total > 0)
				addr = seg_base[$urandom_range(0, seg_total - 1)];
			if (pick < 50) begin
				if ($urandom_range(0, 19) == 0)
					req = $urandom_range(0, 2047);
				else if ($urandom_range(0, 19) == 0)
					req = 0;
				send_request(ffsa_pkg::ACT_ALLOC, req, $urandom_range(0, 1023), random_gap());
			end else if (pick < 90) begin
				send_request(ffsa_pkg::ACT_FREE, $urandom_range(0, 2047), addr, random_gap());
			end else begin
				send_request(ffsa_pkg::ACT_FREE, $urandom_range(0, 2047),
					$urandom_range(0, 1023), random_gap());
			end
		end
	endtask

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: granted %0d status %0d",
						granted_address, status);
			end else begin
				want = pending_grants.pop_front();
				if (want.granted !== granted_address || want.code !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected granted %0d status %0d, got %0d %0d",
							want.granted, want.code, granted_address, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		seg_total = 1;
		for (int i = 0; i < ffsa_pkg::MAX_SEGMENTS; i++) begin
			seg_base[i] = 0;
			seg_len[i] = 0;
			seg_taken[i] = 1'b0;
		end
		seg_len[0] = ffsa_pkg::POOL_BYTES;
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ffsa_pkg::ACT_ALLOC;
		request_size <= '0;
		address <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain();
		test_random(600);
		test_drain();
		test_random(740);
		start <= 1'b0;
		wait (pending_grants.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_grants.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
